// ===== hw/rtl/piecewise_linear_curve_eval_assert.svh =====
// Assertion macros used by the curve evaluator top level.
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLCE_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PLCE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/plce_pkg.sv =====
// Shared types and constants of the piecewise linear curve evaluator.
package plce_pkg;

	// Table size and derived index widths.
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Datapath widths: Q4.12 fields, their differences, product and quotient.
	localparam int FIELD_W   = 16;
	localparam int DIFF_W    = FIELD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int DEN_W     = DIFF_W;
	localparam int DIV_W     = PROD_W;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int QUOT_W    = DIV_W + 1;
	localparam int RES_W     = QUOT_W + 1;

	// Abscissa code that ends the curve (-1.0 in Q4.12).
	localparam logic signed [FIELD_W-1:0] END_MARK = -16'sd4096;

	// Result clipping limits.
	localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32767);
	localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-32768);

	// Input command codes.
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	// One table entry.
	typedef struct packed {
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
	} point_t;

	// Divider request and response.
	typedef struct packed {
		logic                     start;
		logic signed [PROD_W-1:0] num;
		logic signed [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/plce_table.sv =====
// Curve point memory: one write port, one registered read port.
module plce_table
	import plce_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  point_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output point_t           rd_data
);

	point_t mem_q [MAX_POINTS];
	point_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/plce_div.sv =====
// Iterative signed divider, two restoring quotient bits per cycle, truncating toward zero.
module plce_div
	import plce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIX  = 3'b100
	} dstate_t;

	dstate_t                  state_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic [DIV_W-1:0]         qd_q;
	logic [DEN_W-1:0]         rem_q;
	logic [DEN_W-1:0]         d_q;
	logic                     neg_q;
	logic                     done_q;
	logic signed [QUOT_W-1:0] quot_q;

	logic [DIV_W-1:0] num_abs;
	logic [DEN_W-1:0] den_abs;
	logic [DEN_W:0]   step1;
	logic [DEN_W:0]   step2;

	// One restoring step: returns the quotient bit over the new remainder.
	function automatic logic [DEN_W:0] div_step(
		input logic [DEN_W-1:0] rem,
		input logic             bit_in,
		input logic [DEN_W-1:0] d
	);
		logic [DEN_W:0] t;
		t = {rem, bit_in};
		if (t >= {1'b0, d}) begin
			return {1'b1, DEN_W'(t - {1'b0, d})};
		end
		return {1'b0, t[DEN_W-1:0]};
	endfunction

	// Operand magnitudes.
	assign num_abs = req.num[PROD_W-1] ? DIV_W'(-req.num) : DIV_W'(req.num);
	assign den_abs = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);

	// Two chained steps on the two top dividend bits.
	assign step1 = div_step(rem_q, qd_q[DIV_W-1], d_q);
	assign step2 = div_step(step1[DEN_W-1:0], qd_q[DIV_W-2], d_q);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && req.start) begin
			qd_q  <= num_abs;
			d_q   <= den_abs;
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= req.num[PROD_W-1] ^ req.den[DEN_W-1];
		end else if (state_q == D_RUN) begin
			qd_q  <= {qd_q[DIV_W-3:0], step1[DEN_W], step2[DEN_W]};
			rem_q <= step2[DEN_W-1:0];
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
		if (state_q == D_FIX) begin
			quot_q <= neg_q ? -$signed({1'b0, qd_q}) : $signed({1'b0, qd_q});
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== hw/rtl/piecewise_linear_curve_eval.sv =====
// Top level of the piecewise linear curve evaluator: sequencer, scan and result stage.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_ready   | cmd, point_index, point_x, point_y, position
//  out     | out_valid / out_ready | value, segment, saturated
//  cfg     | cfg_valid / cfg_ready | points_in_use
//
// A write beat gives no result. An evaluate beat with fewer than two points gives its
// result in the cycle after acceptance. Otherwise the table scan reads one entry per
// cycle, then, for an interpolated result, come segment setup, one multiply, and the
// divider at two quotient bits per cycle (17 steps plus sign fix).
// The block takes no new beat until the result beat leaves; out_ready low holds it.
// Reset clears control state and points_in_use; the point table is not cleared.
`include "piecewise_linear_curve_eval_assert.svh"

module piecewise_linear_curve_eval
	import plce_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [3:0]                point_index,
	input  logic signed [FIELD_W-1:0] point_x,
	input  logic signed [FIELD_W-1:0] point_y,
	input  logic signed [FIELD_W-1:0] position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] value,
	output logic [3:0]                segment,
	output logic                      saturated,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [4:0]                points_in_use
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_SEG    = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_DSTART = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t                    state_q;
	state_t                    state_nxt;
	logic [4:0]                pim_q;
	logic [CNT_W-1:0]          n_in;
	logic [CNT_W-1:0]          n_q;
	logic signed [FIELD_W-1:0] pos_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          left_q;
	point_t                    prev_q;
	point_t                    cur;
	logic signed [DIFF_W-1:0]  a_q;
	logic signed [DIFF_W-1:0]  b_q;
	logic signed [DEN_W-1:0]   den_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [FIELD_W-1:0] value_q;
	logic [IDX_W-1:0]          segment_q;
	logic                      saturated_q;

	logic                      accept_eval;
	logic                      wr_en;
	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	logic                      scan_cont;
	logic                      scan_last;
	logic                      seg_flat;
	logic signed [RES_W-1:0]   res;
	logic                      res_hi;
	logic                      res_lo;
	logic                      emit;
	logic signed [FIELD_W-1:0] emit_val;
	logic [IDX_W-1:0]          emit_seg;
	logic                      emit_sat;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	// Configuration register; the user must write it only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pim_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pim_q <= points_in_use;
		end
	end

	assign n_in = (pim_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pim_q);

	// Input beat decode.
	assign in_ready    = (state_q == S_IDLE);
	assign accept_eval = in_valid && in_ready && (cmd == CMD_EVAL);
	assign wr_en       = in_valid && in_ready && (cmd == CMD_WRITE)
	                     && (int'(point_index) < MAX_POINTS);

	plce_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(point_index)),
		.wr_data ({point_x, point_y}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (cur)
	);

	// Scan and segment conditions on the entry just read.
	assign scan_cont = (cur.x < pos_q) && (cur.x != END_MARK);
	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;
	assign seg_flat  = (cur.x == prev_q.x) || (cur.x == END_MARK);

	// Divider hookup.
	assign div_req.start = (state_q == S_DSTART);
	assign div_req.num   = prod_q;
	assign div_req.den   = den_q;

	plce_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Final sum and clipping.
	assign res = {{(RES_W - FIELD_W){prev_q.y[FIELD_W-1]}}, prev_q.y}
	             + {{(RES_W - QUOT_W){div_rsp.quot[QUOT_W-1]}}, div_rsp.quot};
	assign res_hi = res > RES_MAX;
	assign res_lo = res < RES_MIN;

	// Next state, memory reads and result selection.
	always_comb begin
		state_nxt = state_q;
		emit      = 1'b0;
		emit_val  = '0;
		emit_seg  = '0;
		emit_sat  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept_eval) begin
					if (n_in < CNT_W'(2)) begin
						emit      = 1'b1;
						state_nxt = S_OUT;
					end else begin
						rd_en     = 1'b1;
						state_nxt = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (pos_q[FIELD_W-1]) begin
					emit      = 1'b1;
					emit_val  = cur.y;
					state_nxt = S_OUT;
				end else if (scan_cont) begin
					if (scan_last) begin
						emit      = 1'b1;
						emit_val  = cur.y;
						emit_seg  = idx_q;
						state_nxt = S_OUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + IDX_W'(1);
					end
				end else begin
					if (idx_q == '0) begin
						rd_en   = 1'b1;
						rd_addr = IDX_W'(1);
					end
					state_nxt = S_SEG;
				end
			end
			S_SEG: begin
				if (seg_flat) begin
					emit      = 1'b1;
					emit_val  = prev_q.y;
					emit_seg  = left_q;
					state_nxt = S_OUT;
				end else begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				state_nxt = S_DSTART;
			end
			S_DSTART: begin
				state_nxt = S_DIV;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					emit      = 1'b1;
					emit_seg  = left_q;
					emit_sat  = res_hi || res_lo;
					if (res_hi) begin
						emit_val = RES_MAX[FIELD_W-1:0];
					end else if (res_lo) begin
						emit_val = RES_MIN[FIELD_W-1:0];
					end else begin
						emit_val = res[FIELD_W-1:0];
					end
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Scan, segment and arithmetic operand registers.
	always_ff @(posedge clk) begin
		if (accept_eval) begin
			pos_q <= position;
			n_q   <= n_in;
			idx_q <= '0;
		end
		if (state_q == S_SCAN && !pos_q[FIELD_W-1]) begin
			if (scan_cont && !scan_last) begin
				idx_q  <= idx_q + IDX_W'(1);
				prev_q <= cur;
			end else if (!scan_cont) begin
				if (idx_q == '0) begin
					prev_q <= cur;
					left_q <= '0;
				end else begin
					left_q <= idx_q - IDX_W'(1);
				end
			end
		end
		if (state_q == S_SEG) begin
			a_q   <= {cur.y[FIELD_W-1], cur.y} - {prev_q.y[FIELD_W-1], prev_q.y};
			b_q   <= {pos_q[FIELD_W-1], pos_q} - {prev_q.x[FIELD_W-1], prev_q.x};
			den_q <= {cur.x[FIELD_W-1], cur.x} - {prev_q.x[FIELD_W-1], prev_q.x};
		end
		if (state_q == S_MUL) begin
			prod_q <= a_q * b_q;
		end
	end

	// Result beat register.
	always_ff @(posedge clk) begin
		if (emit) begin
			value_q     <= emit_val;
			segment_q   <= emit_seg;
			saturated_q <= emit_sat;
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign value     = value_q;
	assign segment   = 4'(segment_q);
	assign saturated = saturated_q;

	// Checks.
	`PLCE_ASSERT_IMPL(a_ready_excl, clk, arst_n, in_ready, !out_valid)
	`PLCE_ASSERT_NEXT(a_eval_busy, clk, arst_n, accept_eval, !in_ready)
	`PLCE_ASSERT_IMPL(a_div_done_state, clk, arst_n, div_rsp.done, state_q == S_DIV)
	`PLCE_ASSERT_IMPL(a_sat_seg, clk, arst_n, out_valid && saturated, (CNT_W'(segment_q) + CNT_W'(1)) < n_q)
	`PLCE_ASSERT_IMPL(a_sat_val, clk, arst_n, out_valid && saturated, value == 16'sh7fff || value == 16'sh8000)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the piecewise linear curve evaluator.
`timescale 1ns / 100ps

module tb_top
	import plce_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_ITEMS    = 200;

	// One beat offered on the input channel.
	typedef struct {
		cmd_t                      op;
		logic [IDX_W-1:0]          slot;
		logic signed [FIELD_W-1:0] px;
		logic signed [FIELD_W-1:0] py;
		logic signed [FIELD_W-1:0] pos;
	} curve_item_t;

	// One result beat as the block should return it.
	typedef struct packed {
		logic signed [FIELD_W-1:0] value;
		logic [3:0]                segment;
		logic                      saturated;
	} curve_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	cmd_t                      cmd = CMD_WRITE;
	logic [3:0]                point_index = '0;
	logic signed [FIELD_W-1:0] point_x = '0;
	logic signed [FIELD_W-1:0] point_y = '0;
	logic signed [FIELD_W-1:0] position = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [FIELD_W-1:0] value;
	logic [3:0]                segment;
	logic                      saturated;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [4:0]                points_in_use = '0;

	// Stimulus and prediction state.
	curve_item_t               curve_items_pending[$];
	curve_result_t             curve_results_due[$];
	logic signed [FIELD_W-1:0] knot_x [MAX_POINTS];
	logic signed [FIELD_W-1:0] knot_y [MAX_POINTS];
	logic [4:0]                scan_len = '0;
	int                        queued_count = 0;
	int                        in_count = 0;
	int                        results_seen = 0;
	int                        fail_count = 0;
	int                        stalled_cycles = 0;
	logic                      in_beat = 1'b0;
	logic                      cfg_beat = 1'b0;
	logic                      idle_on = 1'b1;
	int                        send_gap = 0;
	int                        stall_left = 0;
	int                        hold_left = 0;
	logic                      hold_done = 1'b0;

	piecewise_linear_curve_eval dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.cmd,
		.point_index,
		.point_x,
		.point_y,
		.position,
		.out_valid,
		.out_ready,
		.value,
		.segment,
		.saturated,
		.cfg_valid,
		.cfg_ready,
		.points_in_use
	);

	always #5 clk = ~clk;

	// Expected curve value at a position, from the current table and point count.
	function automatic curve_result_t curve_value_at(logic signed [FIELD_W-1:0] pos);
		curve_result_t r;
		int            n;
		int            left;
		longint        x0, y0, x1, y1, total;
		r = '0;
		n = (scan_len > MAX_POINTS) ? MAX_POINTS : scan_len;
		if (n < 2)
			return r;
		if (pos < 0) begin
			r.value = knot_y[0];
			return r;
		end
		// Walk right while the point lies left of the position, then step back.
		left = 0;
		while (left < n && knot_x[left] < pos && knot_x[left] != END_MARK)
			left++;
		if (left > 0)
			left--;
		r.segment = 4'(left);
		if (left == n - 1) begin
			r.value = knot_y[left];
			return r;
		end
		x0 = knot_x[left];
		y0 = knot_y[left];
		x1 = knot_x[left + 1];
		y1 = knot_y[left + 1];
		// A flat-in-x segment or a segment ending on the marker gives the left y.
		if (x1 == x0 || knot_x[left + 1] == END_MARK) begin
			r.value = knot_y[left];
			return r;
		end
		total = y0 + (y1 - y0) * (longint'(pos) - x0) / (x1 - x0);
		if (total > 32767) begin
			r.value     = 16'sh7fff;
			r.saturated = 1'b1;
		end else if (total < -32768) begin
			r.value     = 16'sh8000;
			r.saturated = 1'b1;
		end else begin
			r.value = 16'(total);
		end
		return r;
	endfunction

	task automatic push_write(int slot, int px, int py);
		curve_item_t it;
		it.op   = CMD_WRITE;
		it.slot = IDX_W'(slot);
		it.px   = 16'(px);
		it.py   = 16'(py);
		it.pos  = 16'($urandom_range(0, 65535));
		curve_items_pending.push_back(it);
		queued_count++;
	endtask

	task automatic push_eval(int pos);
		curve_item_t it;
		it.op   = CMD_EVAL;
		it.slot = IDX_W'($urandom_range(0, MAX_POINTS - 1));
		it.px   = 16'($urandom_range(0, 65535));
		it.py   = 16'($urandom_range(0, 65535));
		it.pos  = 16'(pos);
		curve_items_pending.push_back(it);
		queued_count++;
	endtask

	// Wait until every queued beat is taken and every result has come back.
	task automatic settle();
		do
			@(negedge clk);
		while (in_count != queued_count || curve_results_due.size() != 0);
		// A trailing write beat may still be in flight.
		repeat (4) @(negedge clk);
	endtask

	task automatic set_points(int n);
		settle();
		points_in_use <= 5'(n);
		cfg_valid     <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_beat);
		cfg_valid <= 1'b0;
	endtask

	// A fresh non-decreasing curve over all entries, then mostly evaluations across it.
	task automatic random_phase(int count);
		int reach;
		int mark;
		int slot;
		int k;
		int top;
		reach = $urandom_range(0, 6144);
		mark  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_POINTS - 1) : MAX_POINTS;
		for (slot = 0; slot < MAX_POINTS; slot++) begin
			push_write(slot, (slot == mark) ? int'(END_MARK) : reach, $urandom_range(0, 65535));
			if ($urandom_range(0, 15) != 0)
				reach = reach + $urandom_range(1, 2048);
			if (reach > 32767)
				reach = 32767;
		end
		top = (reach + 1024 > 32767) ? 32767 : reach + 1024;
		for (k = MAX_POINTS; k < count; k++) begin
			case ($urandom_range(0, 9))
				0: push_write($urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
				1: push_eval(-int'($urandom_range(1, 32768)));
				2: push_eval($urandom_range(0, 65535));
				default: push_eval($urandom_range(0, top));
			endcase
		end
	endtask

	// Input driver: offers queued beats with random gaps.
	always @(negedge clk) begin
		curve_item_t nxt;
		if (!in_valid || in_beat) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (!arst_n || curve_items_pending.size() == 0) begin
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				send_gap <= $urandom_range(0, 12);
				in_valid <= 1'b0;
			end else begin
				nxt = curve_items_pending.pop_front();
				cmd         <= nxt.op;
				point_index <= nxt.slot;
				point_x     <= nxt.px;
				point_y     <= nxt.py;
				position    <= nxt.pos;
				in_valid    <= 1'b1;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off to back up the input.
	always @(negedge clk) begin
		if (!hold_done && results_seen >= 60) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: tracks accepted beats, predicts and checks results, runs the watchdog.
	always @(posedge clk) begin
		curve_result_t due;
		in_beat  <= arst_n && in_valid && in_ready;
		cfg_beat <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				scan_len = points_in_use;
			if (in_valid && in_ready) begin
				in_count <= in_count + 1;
				if (cmd == CMD_WRITE) begin
					knot_x[point_index] = point_x;
					knot_y[point_index] = point_y;
				end else begin
					curve_results_due.push_back(curve_value_at(position));
				end
			end
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (curve_results_due.size() == 0) begin
					$error("result beat with no evaluation pending: value %0d", value);
					fail_count++;
				end else begin
					due = curve_results_due.pop_front();
					if (value !== due.value) begin
						$error("value: expected %0d, got %0d", due.value, value);
						fail_count++;
					end
					if (segment !== due.segment) begin
						$error("segment: expected %0d, got %0d", due.segment, segment);
						fail_count++;
					end
					if (saturated !== due.saturated) begin
						$error("saturated: expected %0d, got %0d", due.saturated, saturated);
						fail_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("piecewise_linear_curve_eval regression: fail");
				$finish;
			end
		end
	end

	// Stimulus sequence: directed corner cases, then random phases.
	initial begin
		int phase_points [8];
		int phase;
		phase_points = '{16, 11, 0, 2, 0, 1, 16, 16};
		phase_points[4] = $urandom_range(3, 15);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// No points in use after reset: the result is zero.
		push_eval(32767);
		push_eval(-32768);

		set_points(4);
		push_write(0, 4096, 0);
		push_write(1, 8192, 32767);
		push_write(2, 12288, -32768);
		push_write(3, END_MARK, 1234);
		push_eval(-32768);  // negative position
		push_eval(0);       // extrapolation before the first point
		push_eval(6144);    // plain interpolation with truncation
		push_eval(32767);   // scan stops on the end marker
		// Steep extrapolation clipped low, then high.
		push_write(0, 16384, -32768);
		push_write(1, 20480, 32767);
		push_eval(0);
		push_write(0, 16384, 32767);
		push_write(1, 20480, -32768);
		push_eval(0);
		// Two points sharing one abscissa.
		push_write(0, 8192, 5);
		push_write(1, 8192, 7);
		push_eval(100);

		set_points(2);
		push_write(0, -32768, -32768);
		push_write(1, 0, 32767);
		push_eval(32767);   // past the last point in use
		push_eval(0);       // full-range segment

		set_points(1);
		push_eval(300);

		for (phase = 0; phase < 8; phase++) begin
			set_points(phase_points[phase]);
			idle_on <= (phase != 5 && phase != 7);
			random_phase(PHASE_ITEMS);
		end

		settle();
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("piecewise_linear_curve_eval regression: pass");
		else
			$display("piecewise_linear_curve_eval regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/plce_pkg.sv
hw/rtl/plce_table.sv
hw/rtl/plce_div.sv
hw/rtl/piecewise_linear_curve_eval.sv
tb/tb_top.sv
